// ===== design/bfdh_pkg.sv =====
package bfdh_pkg;
  localparam int MaxBits = 65536;
  localparam int MaxProbes = 10;
  localparam int ByteCount = (MaxBits + 7) / 8;
  localparam int AddrW = $clog2(ByteCount);
  localparam int PosW = $clog2(MaxBits);
  localparam int ModW = PosW + 1;
  localparam int PrbW = 4;
  localparam int QDepth = 2;
  localparam logic [63:0] Golden = 64'h9e3779b97f4a7c15;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic REG_BIT_COUNT = 1'b0;
  localparam logic REG_PROBE_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0] func;
    logic [63:0] key_hash;
  } cmd_t;
endpackage

// ===== design/bfdh_front.sv =====
module bfdh_front import bfdh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [1:0] func,
  input  logic [63:0] key_hash,
  input  logic pop,
  output logic accept_ok,
  output logic q_valid,
  output cmd_t q_head
);
  cmd_t q [QDepth];
  logic [$clog2(QDepth)-1:0] rd_ptr, wr_ptr;
  logic [$clog2(QDepth):0] fill;
  logic push;

  assign accept_ok = (fill != QDepth[$clog2(QDepth):0]);
  assign push = start && accept_ok;
  assign q_valid = (fill != '0);
  assign q_head = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{func: func, key_hash: key_hash};
    end
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + {{$clog2(QDepth){1'b0}}, push} - {{$clog2(QDepth){1'b0}}, pop};
    end
  end
endmodule

// ===== design/bfdh_back.sv =====
module bfdh_back import bfdh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_head,
  input  logic [ModW-1:0] modv,
  input  logic [PrbW-1:0] kv,
  output logic pop,
  output logic done,
  output logic maybe_present,
  output logic [31:0] key_count
);
  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_HASH = 7'b0000100,
    S_GEN  = 7'b0001000,
    S_MOD  = 7'b0010000,
    S_RD   = 7'b0100000,
    S_WR   = 7'b1000000
  } state_t;

  state_t state;
  logic [7:0] mem [ByteCount];
  logic [AddrW-1:0] clr_addr;
  logic [1:0] op;
  logic [63:0] h2, acc;
  logic [63:0] dvd;
  logic [ModW-1:0] rem;
  logic [ModW:0] rem_sh;
  logic [ModW:0] rem_sub;
  logic [6:0] bitn;
  logic [1:0] hstep;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_full;
  logic [PrbW-1:0] idx;
  logic all_set;
  logic [PosW-1:0] pos;
  logic [7:0] rdata;

  // restoring remainder, one dividend bit per cycle
  assign rem_sh = {rem, dvd[63]};
  assign rem_sub = rem_sh - {1'b0, modv};

  // h2 low 64 bits from three 32x32 partial products
  always_comb begin
    case (hstep)
      2'd0: begin
        mul_a = acc[31:0];
        mul_b = Golden[31:0];
      end
      2'd1: begin
        mul_a = acc[31:0];
        mul_b = Golden[63:32];
      end
      default: begin
        mul_a = acc[63:32];
        mul_b = Golden[31:0];
      end
    endcase
  end

  assign mul_full = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    pop <= 1'b0;
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      key_count <= '0;
      maybe_present <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          mem[clr_addr] <= 8'h00;
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AddrW'(ByteCount - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid && !pop) begin
            pop <= 1'b1;
            op <= q_head.func;
            acc <= q_head.key_hash;
            hstep <= '0;
            idx <= '0;
            all_set <= 1'b1;
            case (q_head.func)
              OP_ADD, OP_QUERY: state <= S_HASH;
              OP_CLEAR: begin
                key_count <= '0;
                clr_addr <= '0;
                state <= S_CLR;
                maybe_present <= 1'b0;
                done <= 1'b1;
              end
              default: begin
                maybe_present <= 1'b0;
                done <= 1'b1;
              end
            endcase
          end
        end
        S_HASH: begin
          if (hstep == 2'd0) h2 <= mul_full + 64'd1;
          else h2 <= h2 + {mul_full[31:0], 32'd0};
          hstep <= hstep + 2'd1;
          if (hstep == 2'd2) state <= S_GEN;
        end
        S_GEN: begin
          dvd <= acc;
          rem <= '0;
          bitn <= 7'd63;
          state <= S_MOD;
        end
        S_MOD: begin
          dvd <= {dvd[62:0], 1'b0};
          if (rem_sh >= {1'b0, modv}) rem <= rem_sub[ModW-1:0];
          else rem <= rem_sh[ModW-1:0];
          if (bitn == 7'd0) state <= S_RD;
          else bitn <= bitn - 7'd1;
        end
        S_RD: begin
          pos <= rem[PosW-1:0];
          rdata <= mem[rem[PosW-1:3]];
          state <= S_WR;
        end
        S_WR: begin
          if (!rdata[pos[2:0]]) all_set <= 1'b0;
          if (op == OP_ADD) mem[pos[PosW-1:3]] <= rdata | (8'h01 << pos[2:0]);
          acc <= acc + h2;
          idx <= idx + 1'b1;
          if (idx + 1'b1 == kv) begin
            state <= S_IDLE;
            done <= 1'b1;
            if (op == OP_ADD) begin
              maybe_present <= 1'b0;
              if (key_count != 32'hFFFF_FFFF) key_count <= key_count + 32'd1;
            end else begin
              maybe_present <= all_set && rdata[pos[2:0]];
            end
          end else begin
            state <= S_GEN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/bloom_filter_double_hash_unit.sv =====
// Bloom filter, double hashing. start with busy low transfers one command;
// each command yields one result strobed on done for one cycle, which the
// receiver cannot hold off. Add/query pick up the command, form the second
// hash from three partial products, then run each probe in turn (a 64-step
// bit-serial remainder, then read and write of the bit memory). Clear strobes
// its result at once, then sweeps the 8192-byte memory, one byte a cycle;
// the same sweep runs after reset. A two-entry queue takes commands
// meanwhile; busy is high while it is full.
module bloom_filter_double_hash_unit import bfdh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] func,
  input  logic [63:0] key_hash,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [16:0] cfg_data,
  output logic done,
  output logic maybe_present,
  output logic [31:0] key_count
);
  logic [16:0] bit_count;
  logic [3:0] probe_count;
  logic [ModW-1:0] modv;
  logic [PrbW-1:0] kv;
  logic accept_ok, q_valid, pop;
  cmd_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= 17'd65536;
      probe_count <= 4'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIT_COUNT: bit_count <= cfg_data;
        REG_PROBE_COUNT: probe_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    modv = bit_count;
    if (bit_count < 17'd8) modv = 17'd8;
    if (bit_count > 17'(MaxBits)) modv = 17'(MaxBits);
    kv = probe_count;
    if (probe_count == 4'd0) kv = 4'd1;
    if (probe_count > 4'(MaxProbes)) kv = 4'(MaxProbes);
  end

  assign busy = !accept_ok;

  bfdh_front u_front (
    .clk(clk), .rst(rst), .start(start), .func(func), .key_hash(key_hash),
    .pop(pop), .accept_ok(accept_ok), .q_valid(q_valid), .q_head(q_head)
  );

  bfdh_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_head(q_head), .modv(modv), .kv(kv),
    .pop(pop), .done(done), .maybe_present(maybe_present), .key_count(key_count)
  );
endmodule
